@@ rtl/ssid_pkg.sv @@
`timescale 1ns / 1ps

package ssid_pkg;

    localparam int CAP_DEFAULT = 64;
    localparam int SIZE_W      = 7;
    localparam int VAL_W       = 32;

    // operation codes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DELETE = 1'b1;

    // one input item
    typedef struct packed {
        logic                    mode;
        logic signed [VAL_W-1:0] value;
    } t_in;

    // one result item
    typedef struct packed {
        logic [SIZE_W-1:0]       set_size;
        logic signed [VAL_W-1:0] element;
        logic                    is_empty;
        logic                    full_refused;
        logic                    last;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rd_mid;
        logic cmp;
        logic decide;
        logic out_empty;
        logic issue;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic lo_lt_hi;
        logic new_zero;
        logic k_last;
    } t_stat;

endpackage

@@ rtl/sorted_set_insert_delete.sv @@
`timescale 1ns / 1ps
// the start transfer loads the operand; the binary search then runs its probes, each
// a read state and a compare state, and a decide state fixes the outcome; an empty set
// gives a single flagged result, else the new set is copied to the other bank, one entry
// per cycle through the single read port of each entry ram, and the results come out
// one per cycle; a new operation is taken only when idle; results cannot be stalled
// reset: synchronous active low, empties the set; entry ram is not cleared

module sorted_set_insert_delete #(
    parameter int CAPACITY = ssid_pkg::CAP_DEFAULT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  ssid_pkg::t_in  i_cmd,
    output logic           o_busy,
    output logic           o_res_valid,
    output ssid_pkg::t_out o_res
);
    import ssid_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    ssid_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    ssid_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_in    (i_cmd),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

`ifndef SYNTHESIS
    // results of one operation come out back to back
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.last |=> o_res_valid)
        else $error("result burst broken");

    // elements strictly ascending within a burst
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.last |=> $signed(o_res.element) > $signed($past(o_res.element)))
        else $error("elements not ascending");

    // empty result is alone and has zero size
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.is_empty |-> o_res.last && (o_res.set_size == '0))
        else $error("bad empty result");

    // non-empty result carries a size within capacity
    a_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.is_empty |->
            (o_res.set_size != '0) && (o_res.set_size <= SIZE_W'(CAPACITY)))
        else $error("bad set size");
`endif

endmodule

@@ rtl/ssid_ram.sv @@
`timescale 1ns / 1ps

module ssid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/ssid_ctrl.sv @@
`timescale 1ns / 1ps

module ssid_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  ssid_pkg::t_stat i_stat,
    output ssid_pkg::t_cmd  o_cmd,
    output logic           o_busy
);
    import ssid_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SREQ   = 7'b0000010,
        S_SCMP   = 7'b0000100,
        S_DECIDE = 7'b0001000,
        S_EMPTY  = 7'b0010000,
        S_EMIT   = 7'b0100000,
        S_DRAIN  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SREQ;
                end
            end
            S_SREQ: begin
                if (i_stat.lo_lt_hi) begin
                    o_cmd.rd_mid = 1'b1;
                    n_state      = S_SCMP;
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_SCMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = S_SREQ;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = i_stat.new_zero ? S_EMPTY : S_EMIT;
            end
            S_EMPTY: begin
                o_cmd.out_empty = 1'b1;
                n_state         = S_IDLE;
            end
            S_EMIT: begin
                o_cmd.issue = 1'b1;
                if (i_stat.k_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

@@ rtl/ssid_dp.sv @@
`timescale 1ns / 1ps

module ssid_dp #(
    parameter int CAPACITY = ssid_pkg::CAP_DEFAULT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ssid_pkg::t_in   i_cmd_in,
    input  ssid_pkg::t_cmd  i_cmd,
    output ssid_pkg::t_stat o_stat,
    output logic            o_res_valid,
    output ssid_pkg::t_out  o_res
);
    import ssid_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]           r_count;
    logic                    r_bank;
    logic                    r_mode;
    logic signed [VAL_W-1:0] r_value;
    logic [CW-1:0]           r_lo;
    logic [CW-1:0]           r_hi;
    logic                    r_found;
    logic [CW-1:0]           r_pos;
    logic                    r_ins;
    logic                    r_del;
    logic                    r_ref;
    logic [CW-1:0]           r_k;
    logic [CW-1:0]           r_kd;
    logic                    r_pv;
    logic                    r_ovalid;
    t_out                    r_out;

    logic [CW:0]             sum_lh;
    logic [CW-1:0]           mid;
    logic                    ins_new;
    logic                    n_ins;
    logic                    n_del;
    logic                    n_ref;
    logic [CW-1:0]           new_cnt;
    logic [CW-1:0]           src;
    logic [AW-1:0]           raddr;
    logic [VAL_W-1:0]        rdata0;
    logic [VAL_W-1:0]        rdata1;
    logic signed [VAL_W-1:0] rdata;
    logic signed [VAL_W-1:0] elem;
    logic                    we0;
    logic                    we1;

    // binary search midpoint
    assign sum_lh = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid    = sum_lh[CW:1];

    // outcome of the operation
    always_comb begin
        ins_new = (r_mode == MODE_INSERT) && !r_found;
        n_ins   = ins_new && (r_count != CW'(CAPACITY));
        n_ref   = ins_new && (r_count == CW'(CAPACITY));
        n_del   = (r_mode == MODE_DELETE) && r_found;
        if (n_ins) begin
            new_cnt = r_count + CW'(1);
        end else if (n_del) begin
            new_cnt = r_count - CW'(1);
        end else begin
            new_cnt = r_count;
        end
    end

    // old position feeding output position k
    always_comb begin
        src = r_k;
        if (r_ins && (r_k > r_pos)) begin
            src = r_k - CW'(1);
        end else if (r_del && (r_k >= r_pos)) begin
            src = r_k + CW'(1);
        end
    end

    assign raddr = i_cmd.rd_mid ? mid[AW-1:0] : src[AW-1:0];
    assign rdata = r_bank ? $signed(rdata1) : $signed(rdata0);
    assign elem  = (r_ins && (r_kd == r_pos)) ? r_value : rdata;

    // new set goes to the other bank
    assign we0 = r_pv && r_bank;
    assign we1 = r_pv && !r_bank;

    ssid_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_ram0 (
        .i_clk   (i_clk),
        .i_we    (we0),
        .i_waddr (r_kd[AW-1:0]),
        .i_wdata (elem),
        .i_raddr (raddr),
        .o_rdata (rdata0)
    );

    ssid_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_ram1 (
        .i_clk   (i_clk),
        .i_we    (we1),
        .i_waddr (r_kd[AW-1:0]),
        .i_wdata (elem),
        .i_raddr (raddr),
        .o_rdata (rdata1)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_bank   <= 1'b0;
            r_k      <= '0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= i_cmd.out_empty || r_pv;
            r_pv     <= i_cmd.issue;
            if (i_cmd.decide) begin
                r_count <= new_cnt;
                r_k     <= '0;
            end
            if (i_cmd.issue) begin
                r_k <= r_k + CW'(1);
            end
            // swap banks once the last entry is copied
            if (r_pv && (r_kd == r_count - CW'(1))) begin
                r_bank <= !r_bank;
            end
        end
    end

    // operand, search and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_cmd_in.mode;
            r_value <= i_cmd_in.value;
            r_lo    <= '0;
            r_hi    <= r_count;
            r_found <= 1'b0;
        end
        if (i_cmd.cmp) begin
            if (rdata < r_value) begin
                r_lo <= mid + CW'(1);
            end else begin
                r_hi <= mid;
            end
            if (rdata == r_value) begin
                r_found <= 1'b1;
            end
        end
        if (i_cmd.decide) begin
            r_pos <= r_lo;
            r_ins <= n_ins;
            r_del <= n_del;
            r_ref <= n_ref;
        end
        if (i_cmd.issue) begin
            r_kd <= r_k;
        end
        if (i_cmd.out_empty) begin
            r_out.set_size     <= '0;
            r_out.element      <= '0;
            r_out.is_empty     <= 1'b1;
            r_out.full_refused <= r_ref;
            r_out.last         <= 1'b1;
        end else if (r_pv) begin
            r_out.set_size     <= SIZE_W'(r_count);
            r_out.element      <= elem;
            r_out.is_empty     <= 1'b0;
            r_out.full_refused <= r_ref;
            r_out.last         <= (r_kd == r_count - CW'(1));
        end
    end

    // status to controller
    assign o_stat.lo_lt_hi = (r_lo < r_hi);
    assign o_stat.new_zero = (new_cnt == '0);
    assign o_stat.k_last   = (r_k == r_count - CW'(1));

    assign o_res_valid = r_ovalid;
    assign o_res       = r_out;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import ssid_pkg::*;

    localparam int CAP        = CAP_DEFAULT;
    localparam int RAND_ITEMS = 320;
    localparam int DRAIN_WAIT = 100;

    // expected contents of the set and the results still due from the block
    class set_tracker;
        logic signed [VAL_W-1:0] members[$];
        t_out                    due_results[$];
        int errors;
        int results_checked;
        int ops_insert;
        int ops_delete;
        int dup_inserts;
        int absent_deletes;
        int refusals;
        int peak;

        function new();
            errors = 0;
            results_checked = 0;
            ops_insert = 0;
            ops_delete = 0;
            dup_inserts = 0;
            absent_deletes = 0;
            refusals = 0;
            peak = 0;
        endfunction

        // apply one accepted operation to the set and queue its whole listing
        function void log_op(t_in op);
            logic signed [VAL_W-1:0] v;
            int   pos;
            bit   found;
            bit   refused;
            t_out r;
            v = op.value;
            pos = 0;
            refused = 1'b0;
            while (pos < members.size() && members[pos] < v)
                pos++;
            found = (pos < members.size()) && (members[pos] == v);
            if (op.mode == MODE_INSERT) begin
                ops_insert++;
                if (found) begin
                    dup_inserts++;
                end else if (members.size() >= CAP) begin
                    refused = 1'b1;
                    refusals++;
                end else begin
                    members.insert(pos, v);
                end
            end else begin
                ops_delete++;
                if (found)
                    members.delete(pos);
                else
                    absent_deletes++;
            end
            if (members.size() > peak)
                peak = members.size();

            // empty set gives a single flagged result
            if (members.size() == 0) begin
                r.set_size     = '0;
                r.element      = '0;
                r.is_empty     = 1'b1;
                r.full_refused = refused;
                r.last         = 1'b1;
                due_results.push_back(r);
            end else begin
                for (int k = 0; k < members.size(); k++) begin
                    r.set_size     = SIZE_W'(members.size());
                    r.element      = members[k];
                    r.is_empty     = 1'b0;
                    r.full_refused = refused;
                    r.last         = (k == members.size() - 1);
                    due_results.push_back(r);
                end
            end
        endfunction

        function void report(string field, longint want, longint got);
            errors++;
            $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, field, want, got);
        endfunction

        // compare one result transfer with the oldest expectation
        function void check_result(t_out got);
            t_out want;
            if (due_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual size=%0d elem=%0d last=%0b",
                         $time, got.set_size, $signed(got.element), got.last);
                return;
            end
            want = due_results.pop_front();
            results_checked++;
            if (got.set_size !== want.set_size)
                report("set_size", want.set_size, got.set_size);
            if (got.element !== want.element)
                report("element", $signed(want.element), $signed(got.element));
            if (got.is_empty !== want.is_empty)
                report("is_empty", want.is_empty, got.is_empty);
            if (got.full_refused !== want.full_refused)
                report("full_refused", want.full_refused, got.full_refused);
            if (got.last !== want.last)
                report("last", want.last, got.last);
        endfunction
    endclass

    logic   i_clk   = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_start = 1'b0;
    t_in    i_cmd   = '0;
    logic   o_busy;
    logic   o_res_valid;
    t_out   o_res;

    set_tracker board;

    sorted_set_insert_delete dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_cmd       (i_cmd),
        .o_busy      (o_busy),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // result monitor, values sampled as they were before the edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid)
            board.check_result(o_res);
    end

    // wait out the idle gap, then hold start until the transfer happens
    task automatic send_op(input t_in op, input int gap);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_cmd   <= op;
        do @(posedge i_clk); while (o_busy);
        board.log_op(op);
    endtask

    // operand source: a current member, a tight pool, the extremes or anything
    function automatic logic signed [VAL_W-1:0] pick_value(bit from_set);
        int sel;
        sel = $urandom_range(0, 3);
        if (from_set && board.members.size() > 0)
            return board.members[$urandom_range(0, board.members.size() - 1)];
        case (sel)
            0:       return $signed(32'($urandom_range(0, 15))) - 8;
            1: begin
                case ($urandom_range(0, 5))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return 32'h8000_0001;
                    3:       return 32'h7fff_fffe;
                    4:       return 32'hffff_ffff;
                    default: return 32'h0;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    initial begin
        t_in op;
        t_in dir_ops [23];
        int  sent_rand;
        int  phase_no;
        int  kind;
        int  steps;
        int  tail;
        bit  bursty;
        bit  do_delete;
        bit  phase_done;

        board = new();
        dir_ops = '{
            {MODE_DELETE, 32'h0000_0000},   // absent delete on the empty set
            {MODE_INSERT, 32'h0000_0000},
            {MODE_INSERT, 32'h0000_0000},   // duplicate insert
            {MODE_INSERT, 32'h7fff_ffff},
            {MODE_INSERT, 32'h8000_0000},
            {MODE_INSERT, 32'hffff_ffff},
            {MODE_INSERT, 32'h0000_0001},
            {MODE_INSERT, 32'h8000_0001},
            {MODE_INSERT, 32'h7fff_fffe},
            {MODE_DELETE, 32'h0000_3039},   // absent delete on a populated set
            {MODE_DELETE, 32'h8000_0000},
            {MODE_DELETE, 32'h7fff_ffff},
            {MODE_INSERT, 32'h5555_5555},
            {MODE_INSERT, 32'haaaa_aaaa},
            {MODE_DELETE, 32'h0000_0000},
            {MODE_DELETE, 32'hffff_ffff},
            {MODE_DELETE, 32'h0000_0001},
            {MODE_DELETE, 32'h8000_0001},
            {MODE_DELETE, 32'h7fff_fffe},
            {MODE_DELETE, 32'h5555_5555},
            {MODE_DELETE, 32'haaaa_aaaa},   // back to empty
            {MODE_INSERT, 32'h7fff_ffff},
            {MODE_DELETE, 32'h7fff_ffff}
        };

        // reset
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed operations
        foreach (dir_ops[i])
            send_op(dir_ops[i], $urandom_range(0, 13));

        // random phases: fill to capacity, drain to empty, then mixed traffic
        sent_rand = 0;
        phase_no = 0;
        while (sent_rand < RAND_ITEMS) begin
            kind = phase_no % 3;
            phase_no++;
            bursty = ($urandom_range(0, 3) == 0);
            steps = 0;
            tail = 0;
            phase_done = 1'b0;
            while (!phase_done && sent_rand < RAND_ITEMS) begin
                case (kind)
                    0:       do_delete = ($urandom_range(0, 9) == 0);
                    1:       do_delete = ($urandom_range(0, 9) != 0);
                    default: do_delete = ($urandom_range(0, 1) == 1);
                endcase
                if (do_delete) begin
                    op.mode  = MODE_DELETE;
                    op.value = pick_value($urandom_range(0, 9) < 8);
                end else begin
                    op.mode  = MODE_INSERT;
                    op.value = pick_value($urandom_range(0, 9) == 0);
                end
                send_op(op, bursty ? 0 : $urandom_range(0, 13));
                steps++;
                sent_rand++;
                if (kind == 0 && board.members.size() == CAP)
                    tail++;
                if (kind == 1 && board.members.size() == 0)
                    tail++;
                case (kind)
                    0:       phase_done = (tail >= 20) || (steps >= 150);
                    1:       phase_done = (tail >= 4) || (steps >= 150);
                    default: phase_done = (steps >= 40);
                endcase
            end
        end
        i_start <= 1'b0;

        // drain outstanding results, then watch for stray ones
        while (board.due_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("ran %0d operations (%0d inserts, %0d deletes), %0d results checked",
                 board.ops_insert + board.ops_delete, board.ops_insert, board.ops_delete,
                 board.results_checked);
        $display("peak size %0d, %0d refused inserts, %0d duplicate inserts, %0d absent deletes",
                 board.peak, board.refusals, board.dup_inserts, board.absent_deletes);
        if (board.errors == 0 && board.due_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("%0t: timeout, %0d results still due", $time, board.due_results.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
